@@ hw/rtl/rmq_pkg.sv @@
// Shared types and constants for the rotation matrix to quaternion core.
`timescale 1ns / 1ps

package rmq_pkg;

  localparam int IN_W   = 16;
  localparam int DIFF_W = IN_W + 1;
  localparam int QW_W   = 15;
  localparam int QV_W   = 16;
  localparam int LANES  = 4;

  localparam logic [1:0] LANE_W = 2'd0;
  localparam logic [1:0] LANE_X = 2'd1;
  localparam logic [1:0] LANE_Y = 2'd2;
  localparam logic [1:0] LANE_Z = 2'd3;

  localparam logic [QW_W-1:0] MAG_MAX = 15'h7fff;

  typedef struct packed {
    logic x_neg;
    logic y_neg;
    logic z_neg;
  } sign_t;

endpackage

@@ hw/rtl/rmq_radicand.sv @@
// Diagonal radicand sums and off-diagonal sign differences.
`timescale 1ns / 1ps

module rmq_radicand
  import rmq_pkg::*;
#(
  parameter int FRAC_BITS = 14,
  parameter int UW        = 18
) (
  input  logic signed [IN_W-1:0]  r0c0,
  input  logic signed [IN_W-1:0]  r0c1,
  input  logic signed [IN_W-1:0]  r0c2,
  input  logic signed [IN_W-1:0]  r1c0,
  input  logic signed [IN_W-1:0]  r1c1,
  input  logic signed [IN_W-1:0]  r1c2,
  input  logic signed [IN_W-1:0]  r2c0,
  input  logic signed [IN_W-1:0]  r2c1,
  input  logic signed [IN_W-1:0]  r2c2,
  output logic [LANES-1:0][UW-1:0] rad,
  output sign_t                    sgn
);

  localparam int SW = UW + 1;
  localparam logic signed [SW-1:0] ONE = SW'(1) << FRAC_BITS;

  logic signed [SW-1:0]     a;
  logic signed [SW-1:0]     b;
  logic signed [SW-1:0]     c;
  logic signed [SW-1:0]     s [LANES];
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic signed [DIFF_W-1:0] dz;

  always_comb begin
    a = SW'(r0c0);
    b = SW'(r1c1);
    c = SW'(r2c2);
    s[LANE_W] = ONE + a + b + c;
    s[LANE_X] = ONE + a - b - c;
    s[LANE_Y] = ONE - a + b - c;
    s[LANE_Z] = ONE - a - b + c;
    for (int l = 0; l < LANES; l++) begin
      rad[l] = s[l][SW-1] ? '0 : s[l][UW-1:0];
    end
  end

  always_comb begin
    dx = DIFF_W'(r2c1) - DIFF_W'(r1c2);
    dy = DIFF_W'(r0c2) - DIFF_W'(r2c0);
    dz = DIFF_W'(r1c0) - DIFF_W'(r0c1);
    sgn.x_neg = dx[DIFF_W-1];
    sgn.y_neg = dy[DIFF_W-1];
    sgn.z_neg = dz[DIFF_W-1];
  end

endmodule

@@ hw/rtl/rmq_sqrt_stage.sv @@
// One stage of the digit-by-digit square root, STEPS root bits per lane.
`timescale 1ns / 1ps

module rmq_sqrt_stage
  import rmq_pkg::*;
#(
  parameter int ROOT_W = 16,
  parameter int STEPS  = 2
) (
  input  logic [LANES-1:0][ROOT_W+1:0]   rem_i,
  input  logic [LANES-1:0][ROOT_W-1:0]   root_i,
  input  logic [LANES-1:0][2*ROOT_W-1:0] rad_i,
  output logic [LANES-1:0][ROOT_W+1:0]   rem_o,
  output logic [LANES-1:0][ROOT_W-1:0]   root_o,
  output logic [LANES-1:0][2*ROOT_W-1:0] rad_o
);

  localparam int PW = 2 * ROOT_W;

  always_comb begin
    logic [ROOT_W+1:0] rem;
    logic [ROOT_W+1:0] trial;
    logic [ROOT_W-1:0] root;
    logic [PW-1:0]     rad;
    for (int l = 0; l < LANES; l++) begin
      rem  = rem_i[l];
      root = root_i[l];
      rad  = rad_i[l];
      for (int s = 0; s < STEPS; s++) begin
        rem   = {rem[ROOT_W-1:0], rad[PW-1 -: 2]};
        trial = {root, 2'b01};
        if (rem >= trial) begin
          rem  = rem - trial;
          root = {root[ROOT_W-2:0], 1'b1};
        end else begin
          root = {root[ROOT_W-2:0], 1'b0};
        end
        rad = {rad[PW-3:0], 2'b00};
      end
      rem_o[l]  = rem;
      root_o[l] = root;
      rad_o[l]  = rad;
    end
  end

endmodule

@@ hw/rtl/rmq_format.sv @@
// Halving, saturation and sign application of the four roots.
`timescale 1ns / 1ps

module rmq_format
  import rmq_pkg::*;
#(
  parameter int ROOT_W = 16
) (
  input  logic [LANES-1:0][ROOT_W-1:0] root,
  input  sign_t                         sgn,
  output logic [QW_W-1:0]               quat_w,
  output logic [QV_W-1:0]               quat_x,
  output logic [QV_W-1:0]               quat_y,
  output logic [QV_W-1:0]               quat_z
);

  localparam int EW = ROOT_W + QV_W;

  logic [EW-1:0]        half [LANES];
  logic [LANES-1:0][QW_W-1:0] mag;
  logic [QV_W-1:0]      mx;
  logic [QV_W-1:0]      my;
  logic [QV_W-1:0]      mz;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      half[l] = EW'(root[l][ROOT_W-1:1]);
      mag[l]  = (half[l] > EW'(MAG_MAX)) ? MAG_MAX : half[l][QW_W-1:0];
    end
    mx = {1'b0, mag[LANE_X]};
    my = {1'b0, mag[LANE_Y]};
    mz = {1'b0, mag[LANE_Z]};
    quat_w = mag[LANE_W];
    quat_x = sgn.x_neg ? (~mx + QV_W'(1)) : mx;
    quat_y = sgn.y_neg ? (~my + QV_W'(1)) : my;
    quat_z = sgn.z_neg ? (~mz + QV_W'(1)) : mz;
  end

endmodule

@@ hw/rtl/rotation_matrix_to_quaternion_core.sv @@
// Rotation matrix to quaternion core, top level.
// NS = ceil(ROOT_W / 2), ROOT_W = ceil((max(F,17) + 1 + F) / 2);
//   at FRAC_BITS = 14 there are one radicand stage, eight root stages and one output stage.
// One transaction per cycle unless stalled; each square root stage resolves up to two bits.
// Stalls freeze only full stages; empty stages keep filling.
// Reset (rst_n low, synchronous) clears all stage valid bits; payload is not reset.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_core
  import rmq_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [IN_W-1:0] in_r0c0,
  input  logic signed [IN_W-1:0] in_r0c1,
  input  logic signed [IN_W-1:0] in_r0c2,
  input  logic signed [IN_W-1:0] in_r1c0,
  input  logic signed [IN_W-1:0] in_r1c1,
  input  logic signed [IN_W-1:0] in_r1c2,
  input  logic signed [IN_W-1:0] in_r2c0,
  input  logic signed [IN_W-1:0] in_r2c1,
  input  logic signed [IN_W-1:0] in_r2c2,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [QW_W-1:0]        out_quat_w,
  output logic signed [QV_W-1:0] out_quat_x,
  output logic signed [QV_W-1:0] out_quat_y,
  output logic signed [QV_W-1:0] out_quat_z
);

  localparam int UW     = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1;
  localparam int RW     = UW + FRAC_BITS;
  localparam int ROOT_W = (RW + 1) / 2;
  localparam int PW     = 2 * ROOT_W;
  localparam int RMW    = ROOT_W + 2;
  localparam int NS     = (ROOT_W + 1) / 2;
  localparam int DEPTH  = NS + 2;

  logic [DEPTH-1:0] v_r;
  logic [DEPTH-1:0] v_nxt;
  logic [DEPTH-1:0] rdy;

  logic [LANES-1:0][UW-1:0]  rad_c;
  sign_t                     sgn_c;

  logic [LANES-1:0][RMW-1:0]    rem_r  [0:NS];
  logic [LANES-1:0][ROOT_W-1:0] root_r [0:NS];
  logic [LANES-1:0][PW-1:0]     rad_r  [0:NS];
  sign_t                        sgn_r  [0:NS];

  logic [QW_W-1:0] fw_c;
  logic [QV_W-1:0] fx_c;
  logic [QV_W-1:0] fy_c;
  logic [QV_W-1:0] fz_c;

  logic [QW_W-1:0] quat_w_r;
  logic [QV_W-1:0] quat_x_r;
  logic [QV_W-1:0] quat_y_r;
  logic [QV_W-1:0] quat_z_r;

  always_comb begin
    rdy[DEPTH-1] = !v_r[DEPTH-1] || !out_stall;
    for (int j = DEPTH - 2; j >= 0; j--) begin
      rdy[j] = !v_r[j] || rdy[j+1];
    end
  end

  always_comb begin
    v_nxt = v_r;
    if (rdy[0]) begin
      v_nxt[0] = in_valid;
    end
    for (int j = 1; j < DEPTH; j++) begin
      if (rdy[j]) begin
        v_nxt[j] = v_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall = !rdy[0];

  rmq_radicand #(
    .FRAC_BITS (FRAC_BITS),
    .UW        (UW)
  ) u_radicand (
    .r0c0 (in_r0c0),
    .r0c1 (in_r0c1),
    .r0c2 (in_r0c2),
    .r1c0 (in_r1c0),
    .r1c1 (in_r1c1),
    .r1c2 (in_r1c2),
    .r2c0 (in_r2c0),
    .r2c1 (in_r2c1),
    .r2c2 (in_r2c2),
    .rad  (rad_c),
    .sgn  (sgn_c)
  );

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      for (int l = 0; l < LANES; l++) begin
        rem_r[0][l]  <= '0;
        root_r[0][l] <= '0;
        rad_r[0][l]  <= PW'({rad_c[l], {FRAC_BITS{1'b0}}});
      end
      sgn_r[0] <= sgn_c;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [LANES-1:0][RMW-1:0]    rem_c;
    logic [LANES-1:0][ROOT_W-1:0] root_c;
    logic [LANES-1:0][PW-1:0]     rad_n;

    rmq_sqrt_stage #(
      .ROOT_W (ROOT_W),
      .STEPS  (((ROOT_W - 2 * k) >= 2) ? 2 : 1)
    ) u_sqrt_stage (
      .rem_i  (rem_r[k]),
      .root_i (root_r[k]),
      .rad_i  (rad_r[k]),
      .rem_o  (rem_c),
      .root_o (root_c),
      .rad_o  (rad_n)
    );

    always_ff @(posedge clk) begin
      if (rdy[k+1] && v_r[k]) begin
        rem_r[k+1]  <= rem_c;
        root_r[k+1] <= root_c;
        rad_r[k+1]  <= rad_n;
        sgn_r[k+1]  <= sgn_r[k];
      end
    end
  end

  rmq_format #(
    .ROOT_W (ROOT_W)
  ) u_format (
    .root   (root_r[NS]),
    .sgn    (sgn_r[NS]),
    .quat_w (fw_c),
    .quat_x (fx_c),
    .quat_y (fy_c),
    .quat_z (fz_c)
  );

  always_ff @(posedge clk) begin
    if (rdy[DEPTH-1] && v_r[DEPTH-2]) begin
      quat_w_r <= fw_c;
      quat_x_r <= fx_c;
      quat_y_r <= fy_c;
      quat_z_r <= fz_c;
    end
  end

  assign out_valid  = v_r[DEPTH-1];
  assign out_quat_w = quat_w_r;
  assign out_quat_x = quat_x_r;
  assign out_quat_y = quat_y_r;
  assign out_quat_z = quat_z_r;

`ifndef SYNTHESIS
  a_stall_from_output : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_stall)
    else $error("input stalled while output side is not stalled");

  a_accept_enters : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> v_r[0])
    else $error("accepted transaction did not enter first stage");

  a_reset_empties : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_no_min_value : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_quat_x != 16'h8000) && (out_quat_y != 16'h8000)
                  && (out_quat_z != 16'h8000))
    else $error("vector part exceeds saturated magnitude");
`endif

endmodule
